>>> sv/mrfc_pkg.sv
// Shared types and constants for the Modbus reply frame checker.
package mrfc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [4:0]  pos_t;

  localparam word_t CrcInit   = 16'hFFFF;
  localparam word_t CrcPoly   = 16'hA001;
  localparam pos_t  CrcSpan   = 5'd19;
  localparam pos_t  FrameLen  = 5'd21;
  localparam pos_t  FirstData = 5'd3;
  localparam pos_t  FirstLow  = 5'd4;
  localparam int    WordCount = 8;
  localparam int    WordIdxW  = $clog2(WordCount);

endpackage

>>> sv/mrfc_crc16.sv
// One-byte CRC-16/Modbus update, eight reflected shift steps unrolled.
module mrfc_crc16 (
  input  mrfc_pkg::word_t crc_i,
  input  mrfc_pkg::byte_t data_i,
  output mrfc_pkg::word_t crc_o
);
  import mrfc_pkg::*;

  always_comb begin
    word_t c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

>>> sv/modbus_response_frame_checker.sv
// Top level: checks a 21-byte Modbus RTU register reply and emits its eight words.
// The last frame byte passes the input register, then the result is taken into the output register.
// Throughput: one byte per cycle unless the output stalls; the one-byte CRC update sits
// between the input register and the frame state registers.
// Reset: asynchronous, active low; the block starts idle and ignores bytes until a start flag.
// The output register and input register both empty on reset.
module modbus_response_frame_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrfc_pkg::byte_t     rx_byte_i,
  input  logic                frame_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                frame_ok_o,
  output mrfc_pkg::word_t     soil_temperature_raw_o,
  output mrfc_pkg::word_t     soil_humidity_raw_o,
  output mrfc_pkg::word_t     salinity_value_o,
  output mrfc_pkg::word_t     conductivity_value_o,
  output mrfc_pkg::word_t     ph_raw_o,
  output mrfc_pkg::word_t     nitrogen_value_o,
  output mrfc_pkg::word_t     phosphorus_value_o,
  output mrfc_pkg::word_t     potassium_value_o
);
  import mrfc_pkg::*;

  // Input register
  logic  in_valid_q;
  byte_t in_byte_q;
  logic  in_start_q;

  // Frame state
  pos_t  pos_q, pos_d;
  word_t crc_q, crc_d;
  byte_t hold_q, hold_d;
  logic  match_q, match_d;
  word_t words_q [WordCount];

  // Output register
  logic  out_valid_q, out_valid_d;
  logic  out_ok_q;
  word_t out_words_q [WordCount];

  logic                adv;
  logic                live;
  pos_t                p;
  pos_t                p_off;
  word_t               crc_cur;
  word_t               crc_upd;
  logic                match_cur;
  logic                word_we;
  logic [WordIdxW-1:0] word_idx;
  logic                res_ok;

  // Advance the pipe whenever the output register is free or draining.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q  <= rx_byte_i;
      in_start_q <= frame_start_i;
    end
  end

  mrfc_crc16 u_crc (
    .crc_i  (crc_cur),
    .data_i (in_byte_q),
    .crc_o  (crc_upd)
  );

  always_comb begin
    p         = in_start_q ? '0 : pos_q;
    crc_cur   = in_start_q ? CrcInit : crc_q;
    match_cur = in_start_q ? 1'b0 : match_q;
    live      = in_valid_q && adv && (p < FrameLen);
    p_off     = p - FirstLow;
    word_idx  = p_off[WordIdxW:1];

    pos_d       = pos_q;
    crc_d       = crc_q;
    hold_d      = hold_q;
    match_d     = match_q;
    word_we     = 1'b0;
    res_ok      = 1'b0;
    out_valid_d = adv ? 1'b0 : out_valid_q;

    if (live) begin
      pos_d   = p + 5'd1;
      crc_d   = crc_cur;
      match_d = match_cur;
      if (p < CrcSpan) begin
        crc_d = crc_upd;
        if (p >= FirstData) begin
          if (p[0]) begin
            hold_d = in_byte_q;
          end else begin
            word_we = 1'b1;
          end
        end
      end else if (p == CrcSpan) begin
        match_d = (in_byte_q == crc_cur[7:0]);
      end else begin
        // Last byte: high CRC byte closes the frame.
        res_ok      = match_cur && (in_byte_q == crc_cur[15:8]);
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= FrameLen;
      crc_q       <= CrcInit;
      hold_q      <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      hold_q      <= hold_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      words_q[word_idx] <= {hold_q, in_byte_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_d && adv) begin
      out_ok_q <= res_ok;
      for (int k = 0; k < WordCount; k++) begin
        out_words_q[k] <= res_ok ? words_q[k] : '0;
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign frame_ok_o             = out_ok_q;
  assign soil_temperature_raw_o = out_words_q[0];
  assign soil_humidity_raw_o    = out_words_q[1];
  assign salinity_value_o       = out_words_q[2];
  assign conductivity_value_o   = out_words_q[3];
  assign ph_raw_o               = out_words_q[4];
  assign nitrogen_value_o       = out_words_q[5];
  assign phosphorus_value_o     = out_words_q[6];
  assign potassium_value_o      = out_words_q[7];

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= FrameLen)
    else $error("frame position out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_words_q[0] == '0 && out_words_q[7] == '0))
    else $error("failed frame carries nonzero data");

  a_result_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (pos_q == FrameLen))
    else $error("result issued before frame end");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room in the pipe");

endmodule
